>>> hdl/rc4_stream_cipher_defines.svh
// Assertion macros used by the RC4 cipher checker.
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RC4_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/rc4_pkg.sv
// Shared types and constants of the RC4 stream cipher.
package rc4_pkg;

  localparam int MAX_KEY_BYTES_DEF = 16;
  localparam int KEY_BYTES         = 16;
  localparam int PERM_DEPTH        = 256;
  localparam int APB_AW            = 5;
  localparam int APB_DW            = 64;

  localparam logic [1:0] REG_KEY_LOW    = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH   = 2'd1;
  localparam logic [1:0] REG_KEY_LENGTH = 2'd2;

  localparam logic CMD_INIT  = 1'b0;
  localparam logic CMD_CRYPT = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_in;
  } rc4_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       init_done;
  } rc4_result_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_FILL,
    OP_KS_READ_N,
    OP_KS_READ_J,
    OP_KS_WRITE_J,
    OP_KS_WRITE_N,
    OP_INIT_ACK,
    OP_CR_READ_J,
    OP_CR_SWAP,
    OP_CR_DONE
  } rc4_op_t;

  typedef struct packed {
    rc4_op_t op;
    logic    start_init;
    logic    start_crypt;
    logic    load_result;
  } rc4_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic out_free;
  } rc4_status_t;

endpackage

>>> hdl/rc4_ctrl.sv
// Sequencer of the RC4 cipher: key schedule and per-byte crypt steps.
module rc4_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_command,
  output logic                 item_stall,
  input  rc4_pkg::rc4_status_t status,
  output rc4_pkg::rc4_cmd_t    cmd
);
  import rc4_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE       = 10'b0000000001,
    S_FILL       = 10'b0000000010,
    S_KS_READ_N  = 10'b0000000100,
    S_KS_READ_J  = 10'b0000001000,
    S_KS_WRITE_J = 10'b0000010000,
    S_KS_WRITE_N = 10'b0000100000,
    S_INIT_ACK   = 10'b0001000000,
    S_CR_READ_J  = 10'b0010000000,
    S_CR_SWAP    = 10'b0100000000,
    S_CR_DONE    = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   can_take;
  logic   accept;
  state_t start_state;

  assign can_take    = (state == S_IDLE) || ((state == S_CR_DONE) && status.out_free);
  assign accept      = item_valid && can_take;
  assign item_stall  = !can_take;
  assign start_state = (item_command == CMD_CRYPT) ? S_CR_READ_J : S_FILL;

  always_comb begin
    cmd.start_init  = accept && (item_command == CMD_INIT);
    cmd.start_crypt = accept && (item_command == CMD_CRYPT);
    cmd.load_result = ((state == S_CR_DONE) || (state == S_INIT_ACK)) && status.out_free;
    state_next      = state;
    unique case (state)
      S_IDLE: begin
        cmd.op = OP_IDLE;
        if (accept) state_next = start_state;
      end
      S_FILL: begin
        cmd.op = OP_FILL;
        if (status.idx_last) state_next = S_KS_READ_N;
      end
      S_KS_READ_N: begin
        cmd.op     = OP_KS_READ_N;
        state_next = S_KS_READ_J;
      end
      S_KS_READ_J: begin
        cmd.op     = OP_KS_READ_J;
        state_next = S_KS_WRITE_J;
      end
      S_KS_WRITE_J: begin
        cmd.op     = OP_KS_WRITE_J;
        state_next = S_KS_WRITE_N;
      end
      S_KS_WRITE_N: begin
        cmd.op     = OP_KS_WRITE_N;
        state_next = status.idx_last ? S_INIT_ACK : S_KS_READ_J;
      end
      S_INIT_ACK: begin
        cmd.op = OP_INIT_ACK;
        if (status.out_free) state_next = S_IDLE;
      end
      S_CR_READ_J: begin
        cmd.op     = OP_CR_READ_J;
        state_next = S_CR_SWAP;
      end
      S_CR_SWAP: begin
        cmd.op     = OP_CR_SWAP;
        state_next = S_CR_DONE;
      end
      S_CR_DONE: begin
        cmd.op = OP_CR_DONE;
        if (status.out_free) state_next = accept ? start_state : S_IDLE;
      end
      default: begin
        cmd.op     = OP_IDLE;
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/rc4_datapath.sv
// Permutation memory, indices, key position and result register of the RC4 cipher.
module rc4_datapath #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rc4_pkg::rc4_cmd_t                     cmd,
  output rc4_pkg::rc4_status_t                  status,
  input  logic [7:0]                            data_in,
  input  logic [rc4_pkg::KEY_BYTES-1:0][7:0]    key_bytes,
  input  logic [4:0]                            key_length,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output rc4_pkg::rc4_result_t                  result
);
  import rc4_pkg::*;

  localparam int         KPOS_W  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [4:0] LEN_MAX = 5'(MAX_KEY_BYTES);

  logic [7:0] perm [PERM_DEPTH];
  logic [7:0] rdata;
  logic       we;
  logic       re;
  logic [7:0] waddr;
  logic [7:0] wdata;
  logic [7:0] raddr;

  logic [7:0]        idx_i;
  logic [7:0]        idx_j;
  logic [KPOS_W-1:0] kpos;
  logic [7:0]        a_reg;
  logic [7:0]        b_reg;
  logic [7:0]        t_reg;
  logic [7:0]        data_reg;

  logic [4:0] len_eff;
  logic [4:0] kpos_inc;
  logic [7:0] key_byte;
  logic [7:0] ks_j;
  logic [7:0] cr_j;
  logic [7:0] ks_val;
  logic       out_free;

  assign len_eff  = (key_length == 5'd0) ? 5'd1 :
                    (key_length > LEN_MAX) ? LEN_MAX : key_length;
  assign kpos_inc = 5'(kpos) + 5'd1;
  assign key_byte = key_bytes[4'(kpos)];
  assign ks_j     = idx_j + key_byte + rdata;
  assign cr_j     = idx_j + rdata;
  // Post-swap value at a+b: the swap into j landed last cycle, the one into i lands now.
  assign ks_val   = (t_reg == idx_j) ? a_reg :
                    (t_reg == idx_i) ? b_reg : rdata;
  assign out_free = !result_valid || !result_stall;

  assign status.idx_last = (idx_i == 8'hFF);
  assign status.out_free = out_free;

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = idx_i;
    wdata = b_reg;
    raddr = idx_i + 8'd1;
    unique case (cmd.op)
      OP_FILL: begin
        we    = 1'b1;
        wdata = idx_i;
      end
      OP_KS_READ_N: begin
        re    = 1'b1;
        raddr = idx_i;
      end
      OP_KS_READ_J: begin
        re    = 1'b1;
        raddr = ks_j;
      end
      OP_KS_WRITE_J: begin
        we    = 1'b1;
        waddr = idx_j;
        wdata = a_reg;
      end
      OP_KS_WRITE_N: begin
        we    = 1'b1;
        wdata = rdata;
        re    = 1'b1;
      end
      OP_CR_READ_J: begin
        re    = 1'b1;
        raddr = cr_j;
      end
      OP_CR_SWAP: begin
        we    = 1'b1;
        waddr = idx_j;
        wdata = a_reg;
        re    = 1'b1;
        raddr = a_reg + rdata;
      end
      OP_CR_DONE: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
    if (cmd.start_crypt) begin
      re    = 1'b1;
      raddr = idx_i + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) perm[waddr] <= wdata;
    if (re) rdata <= perm[raddr];
  end

  always_ff @(posedge clk) begin
    if ((cmd.op == OP_KS_READ_J) || (cmd.op == OP_CR_READ_J)) a_reg <= rdata;
    if (cmd.op == OP_CR_SWAP) begin
      b_reg <= rdata;
      t_reg <= a_reg + rdata;
    end
    if (cmd.start_crypt) data_reg <= data_in;
    if (cmd.load_result) begin
      if (cmd.op == OP_INIT_ACK) begin
        result <= '{data_out: 8'h00, init_done: 1'b1};
      end else begin
        result <= '{data_out: data_reg ^ ks_val, init_done: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i        <= '0;
      idx_j        <= '0;
      kpos         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.start_init) begin
        idx_i <= '0;
        idx_j <= '0;
        kpos  <= '0;
      end else if (cmd.start_crypt) begin
        idx_i <= idx_i + 8'd1;
      end else begin
        priority case (cmd.op)
          OP_FILL, OP_KS_WRITE_N: idx_i <= idx_i + 8'd1;
          OP_KS_READ_J: begin
            idx_j <= ks_j;
            kpos  <= (kpos_inc >= len_eff) ? '0 : kpos_inc[KPOS_W-1:0];
          end
          OP_CR_READ_J: idx_j <= cr_j;
          OP_INIT_ACK: begin
            idx_i <= '0;
            idx_j <= '0;
          end
          default: idx_j <= idx_j;
        endcase
      end
      if (cmd.load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/rc4_stream_cipher.sv
// RC4 stream cipher top level: configuration registers, sequencer and datapath.
//
// RC4 stream cipher with one byte-wide simple dual-port permutation memory
// (256 x 8, one write and one registered read per cycle). An init transaction
// (command 0) runs the key schedule with the current key registers and
// clears both indices; its result carries init_done = 1 and data_out = 0.
// The schedule first fills the memory with the identity, then scrambles it
// entry by entry (read S[j], write S[j], write S[i]). A crypt transaction
// (command 1) produces data_in XOR the next keystream byte; the same step
// encrypts and decrypts. A crypt byte steps through the read-j, swap and
// done states; its result is registered in the done state, and the next
// transaction is taken in that same cycle while the result side keeps up.
// The sequence is set by the single read port: three reads (S[i], S[j] and
// S[a+b]) and two swap writes per byte, with the last write overlapped with
// the next byte's first read.
// The result register holds a finished result while stalled; the block then
// holds further input. Key bytes are used cyclically over key_length bytes
// (0 counts as 1, above MAX_KEY_BYTES saturates). Crypt before the first
// init returns undefined data. Write configuration only while idle.
// Registers (APB, 64-bit data): 0x00 key bytes 0..7, 0x08 key bytes 8..15,
// 0x10 key_length (5 bits, reset 5). The unused word at 0x18 ignores writes, reads 0.
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input transaction channel
  input  logic                        item_valid,
  output logic                        item_stall,
  input  rc4_pkg::rc4_item_t          item,
  // result transaction channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output rc4_pkg::rc4_result_t        result,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rc4_pkg::APB_AW-1:0]  paddr,
  input  logic [rc4_pkg::APB_DW-1:0]  pwdata,
  output logic [rc4_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import rc4_pkg::*;

  logic [63:0]                 key_low_bytes;
  logic [63:0]                 key_high_bytes;
  logic [4:0]                  key_length;
  logic [KEY_BYTES-1:0][7:0]   key_bytes;
  logic [1:0]                  reg_sel;
  logic                        reg_write;
  rc4_cmd_t                    cmd;
  rc4_status_t                 status;

  // Registers sit on 8-byte boundaries; decode the word index only.
  assign reg_sel   = paddr[4:3];
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign key_bytes = {key_high_bytes, key_low_bytes};

  // Register writes: key words take the full bus, the length keeps five bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low_bytes  <= '0;
      key_high_bytes <= '0;
      key_length     <= 5'd5;
    end else if (reg_write) begin
      unique case (reg_sel)
        REG_KEY_LOW:    key_low_bytes  <= pwdata;
        REG_KEY_HIGH:   key_high_bytes <= pwdata;
        REG_KEY_LENGTH: key_length     <= pwdata[4:0];
        default:        key_length     <= key_length;
      endcase
    end
  end

  // Read back the addressed register; unmapped words read as zero.
  always_comb begin
    unique case (reg_sel)
      REG_KEY_LOW:    prdata = key_low_bytes;
      REG_KEY_HIGH:   prdata = key_high_bytes;
      REG_KEY_LENGTH: prdata = {59'd0, key_length};
      default:        prdata = '0;
    endcase
  end

  // Sequencer: accepts transactions and steps the datapath through each one.
  rc4_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_command (item.command),
    .item_stall   (item_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Datapath: permutation memory, indices, key position and result register.
  rc4_datapath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .data_in      (item.data_in),
    .key_bytes    (key_bytes),
    .key_length   (key_length),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> hdl/rc4_checker.sv
// Port-level checks of the RC4 cipher, bound to its top level.
`include "rc4_stream_cipher_defines.svh"

module rc4_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_stall,
  input logic                        result_valid,
  input logic                        result_stall,
  input rc4_pkg::rc4_result_t        result
);

  // A stalled result stays and does not change.
  `RC4_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "result changed while stalled")

  // A key schedule acknowledge carries a zero data byte.
  `RC4_ASSERT_NOW(a_init_zero, result_valid && result.init_done, result.data_out == 8'h00, "init acknowledge with nonzero data")

  // Every transaction keeps the block busy after it is taken.
  `RC4_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall ##1 item_stall, "input taken too soon after a transaction")

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

>>> tb/rc4_stream_cipher_tb.sv
// Self-checking testbench for the RC4 stream cipher: directed rows, random streams, key setups.
`timescale 1ns / 100ps

module rc4_stream_cipher_tb;
  import rc4_pkg::*;

  // Index past the end of the register map; writes must be dropped, reads give zero.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int PHASE_COUNT = 7;
  localparam int ITEMS_PER_PHASE = 270;
  localparam int IDLE_PERCENT = 19;
  localparam int INIT_PERCENT = 2;

  typedef struct {
    logic       command;
    logic [7:0] data_in;
    bit         typed;      // expected result given in the row itself
    logic [7:0] want_data;
    logic       want_done;
  } directed_row_t;

  typedef struct {
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [4:0]  key_length;
  } key_setting_t;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  rc4_item_t           item;
  logic                result_valid;
  logic                result_stall;
  rc4_result_t         result;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Cipher state as the block should hold it.
  logic [7:0]  perm_state [PERM_DEPTH];
  logic [7:0]  stream_i;
  logic [7:0]  stream_j;
  logic [63:0] key_low_reg;
  logic [63:0] key_high_reg;
  logic [4:0]  key_length_reg;

  rc4_result_t  pending_results [$];
  int           error_count;
  bit           steady;
  key_setting_t key_settings [PHASE_COUNT];

  // Extremes of both fields, every command, init with a nonzero (ignored) byte, a re-init
  // that must restart the keystream, and back-to-back inits.
  directed_row_t directed_rows [16] = '{
    '{CMD_INIT,  8'h00, 1'b1, 8'h00, 1'b1},
    '{CMD_CRYPT, 8'h00, 1'b0, 8'h00, 1'b0},
    '{CMD_CRYPT, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{CMD_CRYPT, 8'h55, 1'b0, 8'h00, 1'b0},
    '{CMD_CRYPT, 8'hAA, 1'b0, 8'h00, 1'b0},
    '{CMD_CRYPT, 8'h01, 1'b0, 8'h00, 1'b0},
    '{CMD_CRYPT, 8'h80, 1'b0, 8'h00, 1'b0},
    '{CMD_CRYPT, 8'h7F, 1'b0, 8'h00, 1'b0},
    '{CMD_CRYPT, 8'hFE, 1'b0, 8'h00, 1'b0},
    '{CMD_INIT,  8'hFF, 1'b1, 8'h00, 1'b1},
    '{CMD_CRYPT, 8'h00, 1'b0, 8'h00, 1'b0},
    '{CMD_CRYPT, 8'h00, 1'b0, 8'h00, 1'b0},
    '{CMD_INIT,  8'h5A, 1'b1, 8'h00, 1'b1},
    '{CMD_INIT,  8'hA5, 1'b1, 8'h00, 1'b1},
    '{CMD_CRYPT, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{CMD_CRYPT, 8'h00, 1'b0, 8'h00, 1'b0}
  };

  rc4_stream_cipher i_dut (.*);

  always #4 clk = ~clk;

  // Hard stop; the slowest legal run is far shorter than this.
  initial begin
    #4_000_000;
    $display("rc4_stream_cipher verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Key schedule: identity fill, then scramble with the key bytes used cyclically.
  function automatic void schedule_key();
    int unsigned len;
    int unsigned kpos;
    logic [7:0]  acc;
    logic [7:0]  tmp;
    logic [63:0] word;
    len = key_length_reg;
    if (len == 0) len = 1;
    if (len > MAX_KEY_BYTES_DEF) len = MAX_KEY_BYTES_DEF;
    for (int n = 0; n < PERM_DEPTH; n++) perm_state[n] = 8'(n);
    acc = '0;
    kpos = 0;
    for (int n = 0; n < PERM_DEPTH; n++) begin
      word = (kpos < 8) ? key_low_reg : key_high_reg;
      acc = acc + word[(kpos % 8) * 8 +: 8] + perm_state[n];
      tmp = perm_state[n];
      perm_state[n] = perm_state[acc];
      perm_state[acc] = tmp;
      kpos++;
      if (kpos >= len) kpos = 0;
    end
    stream_i = '0;
    stream_j = '0;
  endfunction

  // Advance the cipher by one command and return the result it must produce.
  function automatic rc4_result_t cipher_step(input rc4_item_t it);
    rc4_result_t r;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  sum;
    if (it.command == CMD_INIT) begin
      schedule_key();
      r.data_out = 8'h00;
      r.init_done = 1'b1;
    end else begin
      stream_i = stream_i + 8'd1;
      a = perm_state[stream_i];
      stream_j = stream_j + a;
      b = perm_state[stream_j];
      perm_state[stream_i] = b;
      perm_state[stream_j] = a;
      sum = a + b;
      r.data_out = it.data_in ^ perm_state[sum];
      r.init_done = 1'b0;
    end
    return r;
  endfunction

  // Offer one transaction, with a random gap first unless steady, and hold it until taken.
  task automatic push_item(input rc4_item_t it, input bit typed, input rc4_result_t typed_want);
    rc4_result_t predicted;
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    predicted = cipher_step(it);
    pending_results.push_back(typed ? typed_want : predicted);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the data on the access edge.
  task automatic cfg_write(input logic [1:0] reg_index, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_index)
      REG_KEY_LOW:    key_low_reg = value;
      REG_KEY_HIGH:   key_high_reg = value;
      REG_KEY_LENGTH: key_length_reg = value[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic [1:0] reg_index);
    logic [63:0] want;
    case (reg_index)
      REG_KEY_LOW:    want = key_low_reg;
      REG_KEY_HIGH:   want = key_high_reg;
      REG_KEY_LENGTH: want = {59'd0, key_length_reg};
      default:        want = '0;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {reg_index, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d read 0x%016h, want 0x%016h",
                                reg_index, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stall, dropped during the steady stretch.
  always @(posedge clk) begin
    result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Compare each taken result against the oldest expectation.
  always @(posedge clk) begin
    rc4_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result data_out=0x%02h init_done=%0b",
                                  result.data_out, result.init_done));
      end else begin
        want = pending_results.pop_front();
        if (result.data_out !== want.data_out)
          report_mismatch($sformatf("data_out 0x%02h, want 0x%02h",
                                    result.data_out, want.data_out));
        if (result.init_done !== want.init_done)
          report_mismatch($sformatf("init_done %0b, want %0b",
                                    result.init_done, want.init_done));
      end
    end
  end

  initial begin
    rc4_item_t   it;
    rc4_result_t typed_want;
    clk = 1'b0;
    error_count = 0;
    steady = 1'b0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    // Key setups: length zero acts as one, above sixteen saturates, all-ones keys,
    // a short three-byte key, then random keys.
    key_settings[0] = '{64'd0, 64'd0, 5'd0};
    key_settings[1] = '{{64{1'b1}}, {64{1'b1}}, 5'd16};
    key_settings[2] = '{{$urandom, $urandom}, {$urandom, $urandom}, 5'd31};
    key_settings[3] = '{64'h0000_0000_0079_654B, {$urandom, $urandom}, 5'd3};
    key_settings[4] = '{{$urandom, $urandom}, {$urandom, $urandom}, 5'd17};
    key_settings[5] = '{{$urandom, $urandom}, {$urandom, $urandom}, 5'd1};
    key_settings[6] = '{{$urandom, $urandom}, {$urandom, $urandom},
                        5'($urandom_range(2, 15))};

    key_low_reg = '0;
    key_high_reg = '0;
    key_length_reg = 5'd5;
    stream_i = '0;
    stream_j = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values of the map, unused slot included.
    for (int r = 0; r < 4; r++) cfg_read_check(2'(r));

    // Directed rows run on the reset key; the first row is an init so the
    // permutation is always written before any crypt.
    foreach (directed_rows[k]) begin
      it.command = directed_rows[k].command;
      it.data_in = directed_rows[k].data_in;
      typed_want.data_out = directed_rows[k].want_data;
      typed_want.init_done = directed_rows[k].want_done;
      push_item(it, directed_rows[k].typed, typed_want);
    end
    item_valid <= 1'b0;
    drain_results();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // Block is idle here: reprogram the key, poke the unused slot, read all back.
      cfg_write(REG_KEY_LOW, key_settings[p].key_low);
      cfg_write(REG_KEY_HIGH, key_settings[p].key_high);
      cfg_write(REG_KEY_LENGTH, {59'd0, key_settings[p].key_length});
      cfg_write(REG_UNUSED, {$urandom, $urandom});
      for (int r = 0; r < 4; r++) cfg_read_check(2'(r));

      // One whole phase with neither side idling.
      steady = (p == 2);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Hold the sender once until every result is back.
        if (p == 1 && k == ITEMS_PER_PHASE / 2) begin
          item_valid <= 1'b0;
          drain_results();
        end
        // Start each key with a schedule, then long crypt streams with rare re-inits.
        if (k == 0 || $urandom_range(0, 99) < INIT_PERCENT)
          it.command = CMD_INIT;
        else
          it.command = CMD_CRYPT;
        it.data_in = 8'($urandom_range(0, 255));
        push_item(it, 1'b0, '0);
      end
      item_valid <= 1'b0;
      drain_results();
    end
    steady = 1'b0;

    // Let any stray result show up before the verdict.
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (error_count == 0) begin
      $display("rc4_stream_cipher verification clean");
    end else begin
      $display("rc4_stream_cipher verification failed");
    end
    $finish;
  end

endmodule
